[sv/spi2d_pkg.sv]
// ============================================================================
// spi2d_pkg
// Shared types, constants and outcome codes of the segment intersection block.
// ============================================================================
`default_nettype none
package spi2d_pkg;
    localparam int COORD_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int TOL_BITS          = 34;

    typedef enum logic [1:0] {
        OUT_INTERSECT = 2'd0,
        OUT_PARALLEL  = 2'd1,
        OUT_OUTSIDE_A = 2'd2,
        OUT_OUTSIDE_B = 2'd3
    } outcome_t;

    typedef struct packed {
        logic     vld;
        logic     hit;
        outcome_t outcome;
    } ctl_t;
endpackage
`default_nettype wire

[sv/spi2d_cell.sv]
// ============================================================================
// spi2d_cell
// One restoring division step: takes a partial remainder, emits one quotient bit.
// ============================================================================
`default_nettype none
module spi2d_cell #(
    parameter int RW = 34,
    parameter int QW = 17
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire spi2d_pkg::ctl_t    ctl_in,
    input  wire logic [RW-1:0]      rem_in,
    input  wire logic [RW-1:0]      den_in,
    input  wire logic [QW-1:0]      quo_in,
    input  wire logic               first,
    output spi2d_pkg::ctl_t         ctl_out,
    output logic      [RW-1:0]      rem_out,
    output logic      [RW-1:0]      den_out,
    output logic      [QW-1:0]      quo_out
);
    spi2d_pkg::ctl_t ctl_reg;
    logic [RW-1:0] rem_reg, rem_next, den_reg;
    logic [QW-1:0] quo_reg, quo_next;
    logic [RW:0]   shifted;

    always_comb
    begin
        shifted = first ? {1'b0, rem_in} : {rem_in, 1'b0};
        if (shifted >= {1'b0, den_in})
        begin
            rem_next = RW'(shifted - {1'b0, den_in});
            quo_next = {quo_in[QW-2:0], 1'b1};
        end
        else
        begin
            rem_next = RW'(shifted);
            quo_next = {quo_in[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            den_reg <= den_in;
            quo_reg <= quo_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;
endmodule
`default_nettype wire

[sv/spi2d_front.sv]
// ============================================================================
// spi2d_front
// Differences, cross products, parallel and range tests over three stages.
// ============================================================================
`default_nettype none
module spi2d_front #(
    parameter int CW = 16,
    parameter int RW = 34
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 vld_in,
    input  wire logic signed [CW-1:0]                 asx, asy, aex, aey,
    input  wire logic signed [CW-1:0]                 bsx, bsy, bex, bey,
    input  wire logic [spi2d_pkg::TOL_BITS-1:0]       tol,
    output spi2d_pkg::ctl_t                           ctl_out,
    output logic [RW-1:0]                             num_out,
    output logic [RW-1:0]                             den_out
);
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic                 v1_reg, v2_reg;
    logic signed [DW-1:0] ax_reg, ay_reg, bx_reg, by_reg, dx_reg, dy_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [SW-1:0] den, na, nb;
    logic [SW-1:0]        mden, mna;
    logic                 dpos, ina, inb, par;
    spi2d_pkg::ctl_t      ctl_reg, ctl_next;
    logic [RW-1:0]        num_reg, den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            v1_reg  <= vld_in;
            v2_reg  <= v1_reg;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= DW'(aex) - DW'(asx);
            ay_reg <= DW'(aey) - DW'(asy);
            bx_reg <= DW'(bex) - DW'(bsx);
            by_reg <= DW'(bey) - DW'(bsy);
            dx_reg <= DW'(asx) - DW'(bsx);
            dy_reg <= DW'(asy) - DW'(bsy);
            p0_reg <= by_reg * ax_reg;
            p1_reg <= bx_reg * ay_reg;
            p2_reg <= bx_reg * dy_reg;
            p3_reg <= by_reg * dx_reg;
            p4_reg <= ax_reg * dy_reg;
            p5_reg <= ay_reg * dx_reg;
            num_reg <= RW'(mna);
            den_reg <= RW'(mden);
        end
    end

    always_comb
    begin
        den  = SW'(p0_reg) - SW'(p1_reg);
        na   = SW'(p2_reg) - SW'(p3_reg);
        nb   = SW'(p4_reg) - SW'(p5_reg);
        dpos = !den[SW-1];
        mden = dpos ? den : -den;
        mna  = na[SW-1] ? -na : na;
        ina  = dpos ? (!na[SW-1] && na <= den) : (na <= 0 && na >= den);
        inb  = dpos ? (!nb[SW-1] && nb <= den) : (nb <= 0 && nb >= den);
        par  = (64'(mden) <= 64'(tol));
        ctl_next.vld = v2_reg;
        ctl_next.hit = 1'b0;
        if (par)
        begin
            ctl_next.outcome = spi2d_pkg::OUT_PARALLEL;
        end
        else if (!ina)
        begin
            ctl_next.outcome = spi2d_pkg::OUT_OUTSIDE_A;
        end
        else if (!inb)
        begin
            ctl_next.outcome = spi2d_pkg::OUT_OUTSIDE_B;
        end
        else
        begin
            ctl_next.outcome = spi2d_pkg::OUT_INTERSECT;
            ctl_next.hit     = 1'b1;
        end
    end

    assign ctl_out = ctl_reg;
    assign num_out = num_reg;
    assign den_out = den_reg;
endmodule
`default_nettype wire

[sv/segment_pair_intersect_2d.sv]
// ============================================================================
// segment_pair_intersect_2d
// Fixed-point 2D segment intersection test with a pipelined fraction divider.
// ============================================================================
// One segment pair is taken every cycle while the last stage is empty or its
// result is taken. Each item passes through the cross-product front end and
// then a chain of restoring division cells, one quotient bit per cell; the
// whole pipeline advances only when its last stage is free, so a stalled
// output holds every item in place.
`default_nettype none
module segment_pair_intersect_2d #(
    parameter int COORD_BITS    = spi2d_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = spi2d_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [spi2d_pkg::TOL_BITS-1:0]    cfg_wdata,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [COORD_BITS-1:0]      a_start_x,
    input  wire logic signed [COORD_BITS-1:0]      a_start_y,
    input  wire logic signed [COORD_BITS-1:0]      a_end_x,
    input  wire logic signed [COORD_BITS-1:0]      a_end_y,
    input  wire logic signed [COORD_BITS-1:0]      b_start_x,
    input  wire logic signed [COORD_BITS-1:0]      b_start_y,
    input  wire logic signed [COORD_BITS-1:0]      b_end_x,
    input  wire logic signed [COORD_BITS-1:0]      b_end_y,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   hit,
    output logic [1:0]                             outcome,
    output logic [FRACTION_BITS:0]                 time_fraction
);
    localparam int RW = 2 * (COORD_BITS + 1) + 1;
    localparam int QW = FRACTION_BITS + 1;
    localparam int NC = FRACTION_BITS + 1;

    logic [spi2d_pkg::TOL_BITS-1:0] tol_reg;
    logic                           en;
    spi2d_pkg::ctl_t                ctl   [NC+1];
    logic [RW-1:0]                  rem   [NC+1];
    logic [RW-1:0]                  dv    [NC+1];
    logic [QW-1:0]                  quo   [NC+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    assign en       = !ctl[NC].vld || out_ready;
    assign in_ready = en;

    spi2d_front #(.CW(COORD_BITS), .RW(RW)) u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .vld_in(in_valid),
        .asx(a_start_x), .asy(a_start_y), .aex(a_end_x), .aey(a_end_y),
        .bsx(b_start_x), .bsy(b_start_y), .bex(b_end_x), .bey(b_end_y),
        .tol(tol_reg), .ctl_out(ctl[0]), .num_out(rem[0]), .den_out(dv[0])
    );
    assign quo[0] = '0;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        spi2d_cell #(.RW(RW), .QW(QW)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en), .ctl_in(ctl[i]),
            .rem_in(rem[i]), .den_in(dv[i]), .quo_in(quo[i]), .first(i == 0),
            .ctl_out(ctl[i+1]), .rem_out(rem[i+1]), .den_out(dv[i+1]),
            .quo_out(quo[i+1])
        );
    end

    assign out_valid     = ctl[NC].vld;
    assign hit           = ctl[NC].hit;
    assign outcome       = ctl[NC].outcome;
    assign time_fraction = ctl[NC].hit ? quo[NC] : '0;
endmodule
`default_nettype wire

[sv/spi2d_checker.sv]
// ============================================================================
// spi2d_checker
// Port-level checks on the segment intersection block, bound to the top level.
// ============================================================================
`default_nettype none
module spi2d_checker #(
    parameter int FRACTION_BITS = spi2d_pkg::FRACTION_BITS_DEF
) (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_ready,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic                     hit,
    input wire logic [1:0]               outcome,
    input wire logic [FRACTION_BITS:0]   time_fraction
);
    a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit == (outcome == spi2d_pkg::OUT_INTERSECT)))
        else $error("hit disagrees with outcome");
    a_frac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (time_fraction == '0))
        else $error("fraction set without a hit");
    a_frac_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (time_fraction <= (1 << FRACTION_BITS)))
        else $error("fraction above one");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ready || !out_valid) |-> in_ready)
        else $error("input stalled while output free");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(time_fraction)))
        else $error("stalled result changed");
endmodule

bind segment_pair_intersect_2d spi2d_checker #(.FRACTION_BITS(FRACTION_BITS)) u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
    .out_ready(out_ready), .hit(hit), .outcome(outcome),
    .time_fraction(time_fraction)
);
`default_nettype wire
